// File: sv/icmp_echo_reply_checker_top_assert.svh
// Assertion macros for the ICMP echo reply checker.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef ICMP_ECHO_REPLY_CHECKER_TOP_ASSERT_SVH
`define ICMP_ECHO_REPLY_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ICMP_ERC_AST_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("icmp_erc assertion failed");

// next-cycle implication, disabled while reset is low
`define ICMP_ERC_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("icmp_erc assertion failed");

`endif

// File: sv/icmp_erc_pkg.sv
// Package for the ICMP echo reply checker: beat types, status codes,
// register indexes and protocol constants. No dependencies.
package icmp_erc_pkg;

	localparam int unsigned ICMP_BYTES_W = 11;
	localparam int unsigned STATUS_W     = 3;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OTHER_ID  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_SEQ   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_PAD   = 3'd5;

	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_SEQ    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LENGTH = 2'd2;

	localparam logic [7:0]  PAD_BYTE      = 8'hA5;
	localparam logic [7:0]  ECHO_REPLY    = 8'h00;
	localparam int unsigned ECHO_HEADER   = 8;
	localparam int unsigned WORD_BYTES    = 4;
	localparam int unsigned MIN_IHL       = 5;
	localparam int unsigned ID_END        = 6;
	localparam logic [ICMP_BYTES_W-1:0] ICMP_MAX = 11'd2047;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [7:0]              ttl;
		logic [ICMP_BYTES_W-1:0] icmp_bytes;
	} out_beat_t;

endpackage

// File: sv/icmp_echo_reply_checker_top.sv
// ICMP echo reply checker, top level.
// Depends on icmp_erc_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | sink      | in_valid / in_stall    | in_data  (rx_byte, last_byte)
//  out     | source    | out_valid / out_stall  | out_data (status, ttl, icmp_bytes)
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; every byte updates the per-packet
// state in the cycle it is accepted, and the last byte loads its result into
// the output register, or into the skid entry when that register cannot take it.
// Results leave through a two-entry buffer (output register plus skid), so
// input keeps flowing while one result waits; in_stall rises only when both
// entries are full. Reset (arst_n low) clears packet state, buffers and
// registers to their defaults at once; no clearing pass. cfg_ready is always high.
module icmp_echo_reply_checker_top
	import icmp_erc_pkg::*;
#(
	parameter int unsigned MAX_PACKET      = 2048,
	parameter int unsigned TIMESTAMP_BYTES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_beat_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_beat_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// byte counter saturates at MAX_PACKET-1
	localparam int unsigned CNT_W  = $clog2(MAX_PACKET);
	localparam int unsigned WIDE_W = (CNT_W > ICMP_BYTES_W) ? CNT_W : ICMP_BYTES_W;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_PACKET - 1);
	localparam logic [CNT_W-1:0] PAD_START = CNT_W'(ECHO_HEADER + TIMESTAMP_BYTES);

	// configuration registers
	logic [15:0]             exp_id_q;
	logic [15:0]             exp_seq_q;
	logic [ICMP_BYTES_W-1:0] exp_len_q;

	// per-packet state
	logic [CNT_W-1:0] byte_count_q;
	logic [5:0]       hdr_bytes_q;
	logic [7:0]       ttl_q;
	logic [7:0]       type_q;
	logic [7:0]       pend_hi_q;
	logic             id_wrong_q;
	logic             seq_wrong_q;
	logic             pad_wrong_q;

	// result buffer
	logic      out_valid_q;
	out_beat_t out_q;
	logic      skid_valid_q;
	out_beat_t skid_q;

	logic             in_acc;
	logic             new_res;
	logic             out_free;
	logic [3:0]       ihl;
	logic [5:0]       hdr_cur;
	logic [CNT_W-1:0] hdr_ext;
	logic [CNT_W-1:0] off;
	logic             in_icmp;
	logic [CNT_W-1:0] count_nxt;
	logic [7:0]       ttl_nxt;
	logic [7:0]       type_nxt;
	logic [7:0]       pend_nxt;
	logic             id_wrong_nxt;
	logic             seq_wrong_nxt;
	logic             pad_wrong_nxt;
	logic [15:0]      word;
	logic [WIDE_W-1:0] icmp_wide;
	logic [ICMP_BYTES_W-1:0] icmp;
	out_beat_t        res;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !in_stall;
	assign new_res   = in_acc && in_data.last_byte;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// byte decode: header length on byte 0, then offsets into the ICMP header
	always_comb begin
		ihl      = in_data.rx_byte[3:0];
		hdr_cur  = hdr_bytes_q;
		if (byte_count_q == '0) begin
			hdr_cur = (ihl < 4'(MIN_IHL)) ? 6'(MIN_IHL * WORD_BYTES) : {ihl, 2'b00};
		end
		hdr_ext  = CNT_W'(hdr_cur);
		in_icmp  = byte_count_q >= hdr_ext;
		off      = byte_count_q - hdr_ext;
		word     = {pend_hi_q, in_data.rx_byte};

		ttl_nxt       = (byte_count_q == CNT_W'(8)) ? in_data.rx_byte : ttl_q;
		type_nxt      = type_q;
		pend_nxt      = pend_hi_q;
		id_wrong_nxt  = id_wrong_q;
		seq_wrong_nxt = seq_wrong_q;
		pad_wrong_nxt = pad_wrong_q;
		if (in_icmp) begin
			priority if (off == CNT_W'(0)) begin
				type_nxt = in_data.rx_byte;
			end else if (off == CNT_W'(4) || off == CNT_W'(6)) begin
				pend_nxt = in_data.rx_byte;
			end else if (off == CNT_W'(5)) begin
				id_wrong_nxt = word != exp_id_q;
			end else if (off == CNT_W'(7)) begin
				seq_wrong_nxt = word != exp_seq_q;
			end else begin
				// code, checksum and timestamp bytes pass, every later byte must be padding
				pad_wrong_nxt = pad_wrong_q ||
					(off >= PAD_START && in_data.rx_byte != PAD_BYTE);
			end
		end

		count_nxt = (byte_count_q < COUNT_CAP) ? byte_count_q + CNT_W'(1) : byte_count_q;

		// ICMP length after this byte, clamped to the field width
		icmp_wide = (count_nxt > hdr_ext) ? WIDE_W'(count_nxt - hdr_ext) : '0;
		icmp = (icmp_wide > WIDE_W'(ICMP_MAX)) ? ICMP_MAX : icmp_wide[ICMP_BYTES_W-1:0];

		res.ttl        = ttl_nxt;
		res.icmp_bytes = icmp;
		priority if (icmp < ICMP_BYTES_W'(ID_END)) begin
			res.status = ST_TOO_SHORT;
		end else if (id_wrong_nxt) begin
			res.status = ST_OTHER_ID;
		end else if (icmp < ICMP_BYTES_W'(ECHO_HEADER) || icmp < exp_len_q) begin
			res.status = ST_TOO_SHORT;
		end else if (type_nxt != ECHO_REPLY) begin
			res.status = ST_BAD_TYPE;
		end else if (seq_wrong_nxt) begin
			res.status = ST_BAD_SEQ;
		end else if (pad_wrong_nxt) begin
			res.status = ST_BAD_PAD;
		end else begin
			res.status = ST_OK;
		end
	end

	// configuration writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q  <= 16'd0;
			exp_seq_q <= 16'd1;
			exp_len_q <= 11'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_EXPECTED_ID:     exp_id_q  <= cfg_data;
				CFG_EXPECTED_SEQ:    exp_seq_q <= cfg_data;
				CFG_EXPECTED_LENGTH: exp_len_q <= cfg_data[ICMP_BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// packet state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			hdr_bytes_q  <= 6'(MIN_IHL * WORD_BYTES);
			ttl_q        <= '0;
			type_q       <= '0;
			pend_hi_q    <= '0;
			id_wrong_q   <= 1'b0;
			seq_wrong_q  <= 1'b0;
			pad_wrong_q  <= 1'b0;
		end else if (in_acc) begin
			if (in_data.last_byte) begin
				byte_count_q <= '0;
				hdr_bytes_q  <= 6'(MIN_IHL * WORD_BYTES);
				ttl_q        <= '0;
				type_q       <= '0;
				pend_hi_q    <= '0;
				id_wrong_q   <= 1'b0;
				seq_wrong_q  <= 1'b0;
				pad_wrong_q  <= 1'b0;
			end else begin
				byte_count_q <= count_nxt;
				hdr_bytes_q  <= hdr_cur;
				ttl_q        <= ttl_nxt;
				type_q       <= type_nxt;
				pend_hi_q    <= pend_nxt;
				id_wrong_q   <= id_wrong_nxt;
				seq_wrong_q  <= seq_wrong_nxt;
				pad_wrong_q  <= pad_wrong_nxt;
			end
		end
	end

	// result buffer: skid entry feeds the output register first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || new_res;
			skid_valid_q <= skid_valid_q && new_res;
		end else if (new_res) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (new_res) begin
					skid_q <= res;
				end
			end else if (new_res) begin
				out_q <= res;
			end
		end else if (new_res) begin
			skid_q <= res;
		end
	end

endmodule

// File: sv/icmp_erc_checker.sv
// Port-level checker for the ICMP echo reply checker, with its bind.
// Depends on icmp_erc_pkg and icmp_echo_reply_checker_top_assert.svh.
`include "icmp_echo_reply_checker_top_assert.svh"

module icmp_erc_checker
	import icmp_erc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	`ICMP_ERC_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ICMP_ERC_AST_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
	`ICMP_ERC_AST_SAME(a_short_status, out_valid && out_data.icmp_bytes < ICMP_BYTES_W'(ID_END), out_data.status == ST_TOO_SHORT)
	`ICMP_ERC_AST_SAME(a_ok_len, out_valid && out_data.status == ST_OK, out_data.icmp_bytes >= ICMP_BYTES_W'(ECHO_HEADER))

endmodule

bind icmp_echo_reply_checker_top icmp_erc_checker u_icmp_erc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: verif/icmp_echo_reply_checker_top_tb.sv
// Self-checking bench for icmp_echo_reply_checker_top: streams IPv4/ICMP packets byte by
// byte, predicts each reply verdict and compares it with the result beats.
// Depends on icmp_erc_pkg and the checker top level only.
module icmp_echo_reply_checker_top_tb;
	import icmp_erc_pkg::*;

	localparam int unsigned MAX_PACKET      = 2048;
	localparam int unsigned TIMESTAMP_BYTES = 16;
	localparam int unsigned CYCLE_LIMIT     = 500000;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned MAX_REPORTS     = 10;
	// index 3 is not mapped to any register; writes there must be dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

	// what is wrong with a generated echo reply
	typedef enum {
		PKT_GOOD,
		PKT_OTHER_ID,
		PKT_BAD_TYPE,
		PKT_BAD_SEQ,
		PKT_BAD_PAD,
		PKT_BAD_TAIL
	} pkt_flaw_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_beat_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_beat_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	icmp_echo_reply_checker_top #(
		.MAX_PACKET     (MAX_PACKET),
		.TIMESTAMP_BYTES(TIMESTAMP_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Bench-wide bookkeeping
	// ------------------------------------------------------------------
	in_beat_t    pending_bytes[$];   // bytes waiting for the driver
	out_beat_t   awaited_verdicts[$]; // predicted verdicts, oldest first
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned queued_bytes = 0;
	int unsigned queued_packets = 0;
	int unsigned bytes_fed = 0;
	int unsigned verdicts_checked = 0;
	int unsigned status_hits[0:7];

	// register values as last written by the stimulus side (packet builder)
	logic [15:0] cfg_id_now = 16'd0;
	logic [15:0] cfg_seq_now = 16'd1;
	int unsigned cfg_len_now = 64;

	// ------------------------------------------------------------------
	// Verdict predictor: its own copy of registers and per-packet state
	// ------------------------------------------------------------------
	logic [15:0] exp_id;
	logic [15:0] exp_seq;
	logic [10:0] exp_len;
	logic [10:0] rx_count;   // saturating byte position within the packet
	logic [5:0]  hdr_len;    // IP header length in bytes
	logic [7:0]  ttl_hold;
	logic [7:0]  type_hold;
	logic [7:0]  hi_hold;    // upper byte of id or seq, waiting for its low byte
	logic        id_bad;
	logic        seq_bad;
	logic        pad_bad;

	function automatic void clear_packet_state();
		rx_count  = '0;
		hdr_len   = 6'd20;
		ttl_hold  = '0;
		type_hold = '0;
		hi_hold   = '0;
		id_bad    = 1'b0;
		seq_bad   = 1'b0;
		pad_bad   = 1'b0;
	endfunction

	// Folds one byte into the packet state; returns 1 with the verdict on a last byte.
	function automatic bit absorb_byte(input in_beat_t beat, output out_beat_t verdict);
		logic [10:0]      pos;
		logic [10:0]      off;
		logic [3:0]       ihl;
		int unsigned      icmp_len;
		logic [STATUS_W-1:0] st;
		pos = rx_count;
		verdict = '0;
		if (pos == 0) begin
			ihl = beat.rx_byte[3:0];
			if (ihl < MIN_IHL)
				ihl = 4'(MIN_IHL);
			hdr_len = 6'(ihl * WORD_BYTES);
		end
		if (pos == 8)
			ttl_hold = beat.rx_byte;
		if (pos >= hdr_len) begin
			off = pos - hdr_len;
			if (off == 0)
				type_hold = beat.rx_byte;
			else if (off == 4 || off == 6)
				hi_hold = beat.rx_byte;
			else if (off == 5)
				id_bad = {hi_hold, beat.rx_byte} != exp_id;
			else if (off == 7)
				seq_bad = {hi_hold, beat.rx_byte} != exp_seq;
			else if (off >= ECHO_HEADER + TIMESTAMP_BYTES && beat.rx_byte != PAD_BYTE)
				pad_bad = 1'b1;
		end
		if (rx_count < MAX_PACKET - 1)
			rx_count++;
		if (!beat.last_byte)
			return 0;

		icmp_len = (rx_count > hdr_len) ? rx_count - hdr_len : 0;
		if (icmp_len > ICMP_MAX)
			icmp_len = ICMP_MAX;
		if (icmp_len < ID_END)
			st = ST_TOO_SHORT;
		else if (id_bad)
			st = ST_OTHER_ID;
		else if (icmp_len < ECHO_HEADER || icmp_len < exp_len)
			st = ST_TOO_SHORT;
		else if (type_hold != ECHO_REPLY)
			st = ST_BAD_TYPE;
		else if (seq_bad)
			st = ST_BAD_SEQ;
		else if (pad_bad)
			st = ST_BAD_PAD;
		else
			st = ST_OK;
		verdict.status     = st;
		verdict.ttl        = ttl_hold;
		verdict.icmp_bytes = 11'(icmp_len);
		clear_packet_state();
		return 1;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued bytes, with random idle cycles
	// ------------------------------------------------------------------
	// A new beat may only be presented once the current one has gone
	// (valid low, or valid high with no stall at this edge).
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_data  <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, independent of out_valid.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= $urandom_range(99) < stall_pct;
	end

	// ------------------------------------------------------------------
	// Monitor: tracks config writes, predicts on accepted bytes, checks results
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		out_beat_t got;
		if (!arst_n) begin
			exp_id  = 16'd0;
			exp_seq = 16'd1;
			exp_len = 11'd64;
			clear_packet_state();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_EXPECTED_ID:     exp_id  = cfg_data;
					CFG_EXPECTED_SEQ:    exp_seq = cfg_data;
					CFG_EXPECTED_LENGTH: exp_len = cfg_data[10:0];
					default: ;
				endcase
			end
			// predict first, so a same-edge result can never be missed
			if (in_valid && !in_stall) begin
				bytes_fed++;
				if (absorb_byte(in_data, want))
					awaited_verdicts.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = out_data;
				if (awaited_verdicts.size() == 0) begin
					note_failure($sformatf("unexpected result status %0d ttl %0d bytes %0d",
						got.status, got.ttl, got.icmp_bytes));
				end else begin
					want = awaited_verdicts.pop_front();
					verdicts_checked++;
					status_hits[got.status]++;
					if (got.status !== want.status || got.ttl !== want.ttl ||
							got.icmp_bytes !== want.icmp_bytes)
						note_failure($sformatf(
							"exp status %0d ttl %0d bytes %0d, got status %0d ttl %0d bytes %0d",
							want.status, want.ttl, want.icmp_bytes,
							got.status, got.ttl, got.icmp_bytes));
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_verdicts.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] value, input logic last);
		in_beat_t beat;
		beat.rx_byte   = value;
		beat.last_byte = last;
		pending_bytes.push_back(beat);
		queued_bytes++;
		if (last)
			queued_packets++;
	endtask

	// Echo reply: IPv4 header (IHL as given), ICMP header, timestamp, 0xA5 padding.
	task automatic queue_echo_reply(input logic [3:0] ihl, input int unsigned icmp_len,
			input pkt_flaw_e flaw);
		int unsigned hdr;
		int unsigned total;
		int unsigned off;
		int unsigned bad_at;
		logic [15:0] id;
		logic [15:0] seq;
		logic [7:0]  b;
		hdr   = ((ihl < MIN_IHL) ? MIN_IHL : ihl) * WORD_BYTES;
		total = hdr + icmp_len;
		id    = (flaw == PKT_OTHER_ID) ? cfg_id_now ^ 16'($urandom_range(65535, 1)) : cfg_id_now;
		seq   = (flaw == PKT_BAD_SEQ) ? cfg_seq_now ^ 16'($urandom_range(65535, 1)) : cfg_seq_now;
		bad_at = total; // no padding fault
		if (flaw == PKT_BAD_TAIL)
			bad_at = total - 1;
		else if (flaw == PKT_BAD_PAD && icmp_len > ECHO_HEADER + TIMESTAMP_BYTES)
			bad_at = $urandom_range(total - 1, hdr + ECHO_HEADER + TIMESTAMP_BYTES);
		for (int unsigned i = 0; i < total; i++) begin
			off = i - hdr;
			if (i == 0)
				b = {4'h4, ihl};
			else if (i < hdr)
				b = 8'($urandom);
			else if (off == 0)
				b = (flaw == PKT_BAD_TYPE) ? 8'($urandom_range(255, 1)) : ECHO_REPLY;
			else if (off == 4)
				b = id[15:8];
			else if (off == 5)
				b = id[7:0];
			else if (off == 6)
				b = seq[15:8];
			else if (off == 7)
				b = seq[7:0];
			else if (off < ECHO_HEADER + TIMESTAMP_BYTES)
				b = 8'($urandom);
			else
				b = PAD_BYTE;
			if (i == bad_at && off >= ECHO_HEADER + TIMESTAMP_BYTES)
				b = PAD_BYTE ^ 8'($urandom_range(255, 1));
			push_byte(b, i == total - 1);
		end
	endtask

	task automatic queue_noise(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			push_byte(8'($urandom), i == len - 1);
	endtask

	// Replies of at least the required length, about half of them with a fault,
	// plus truncated replies and plain garbage.
	task automatic queue_random_traffic(input int unsigned min_bytes,
			input int unsigned min_packets);
		int unsigned start_bytes;
		int unsigned n;
		int unsigned roll;
		int unsigned pick;
		logic [3:0]  ihl;
		pkt_flaw_e   flaw;
		start_bytes = queued_bytes;
		n = 0;
		while (queued_bytes - start_bytes < min_bytes || n < min_packets) begin
			roll = $urandom_range(99);
			pick = $urandom_range(9);
			flaw = (pick < 5) ? pkt_flaw_e'(pick + 1) : PKT_GOOD;
			ihl  = ($urandom_range(99) < 70) ? 4'd5 : 4'($urandom_range(15));
			if (roll < 65)
				queue_echo_reply(ihl, cfg_len_now + $urandom_range(24), flaw);
			else if (roll < 80)
				queue_echo_reply(ihl, $urandom_range(cfg_len_now), flaw);
			else
				queue_noise($urandom_range(48, 1));
			n++;
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] id, input logic [15:0] seq,
			input logic [10:0] len);
		write_reg(CFG_EXPECTED_ID, id);
		write_reg(CFG_EXPECTED_SEQ, seq);
		write_reg(CFG_EXPECTED_LENGTH, {5'd0, len});
		cfg_id_now  = id;
		cfg_seq_now = seq;
		cfg_len_now = len;
	endtask

	// Sender holds off until every queued byte is in and every verdict is out,
	// then lets the block settle so it is idle before any register write.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || awaited_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		foreach (status_hits[i])
			status_hits[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values (id 0, seq 1, length 64), no idling.
		queue_echo_reply(4'd5, 64, PKT_GOOD);
		queue_echo_reply(4'd15, 64, PKT_GOOD);   // largest IP header
		queue_echo_reply(4'd0, 64, PKT_GOOD);    // small IHL treated as 5
		queue_echo_reply(4'd4, 70, PKT_BAD_PAD);
		queue_echo_reply(4'd5, 64, PKT_OTHER_ID);
		queue_echo_reply(4'd5, 64, PKT_BAD_TYPE);
		queue_echo_reply(4'd5, 64, PKT_BAD_SEQ);
		queue_echo_reply(4'd5, 5, PKT_OTHER_ID); // too short to hold the id
		queue_echo_reply(4'd5, 6, PKT_OTHER_ID); // id check wins over length
		queue_echo_reply(4'd5, 7, PKT_GOOD);     // incomplete ICMP header
		queue_echo_reply(4'd5, 63, PKT_GOOD);    // one short of the required length
		queue_echo_reply(4'd5, 0, PKT_GOOD);     // IP header only
		queue_echo_reply(4'd5, 66, PKT_BAD_TAIL);
		queue_noise(1);                          // ends before the TTL
		queue_noise(9);
		drain();

		// Register extremes, plus a write to the unmapped index.
		set_config(16'hFFFF, 16'h0000, 11'd24);
		write_reg(CFG_UNMAPPED, 16'($urandom));
		queue_echo_reply(4'd5, 24, PKT_GOOD);
		queue_echo_reply(4'd5, 24, PKT_BAD_SEQ);
		queue_echo_reply(4'd15, 25, PKT_BAD_TAIL);
		queue_echo_reply(4'd5, 25, PKT_GOOD);
		drain();

		// Random traffic under each idling pattern and a new register setting.
		set_config(16'($urandom), 16'($urandom), 11'd24);
		queue_random_traffic(100, 3);
		drain();

		send_idle_pct = 84;
		set_config(16'h0000, 16'hFFFF, 11'd40);
		queue_random_traffic(100, 3);
		drain();

		send_idle_pct = 0;
		stall_pct = 84;
		set_config(16'($urandom), 16'($urandom), 11'd0);
		queue_random_traffic(100, 3);
		drain();

		send_idle_pct = 30;
		stall_pct = 30;
		set_config(16'($urandom), 16'($urandom), 11'(24 + $urandom_range(16)));
		queue_random_traffic(100, 3);
		drain();

		if (awaited_verdicts.size() != 0)
			note_failure($sformatf("%0d results never arrived", awaited_verdicts.size()));
		$display("Streamed %0d bytes in %0d packets over %0d cycles, %0d verdicts checked.",
			bytes_fed, queued_packets, cycle_count, verdicts_checked);
		$display("Verdicts: ok %0d, other id %0d, too short %0d, type %0d, seq %0d, pad %0d",
			status_hits[ST_OK], status_hits[ST_OTHER_ID], status_hits[ST_TOO_SHORT],
			status_hits[ST_BAD_TYPE], status_hits[ST_BAD_SEQ], status_hits[ST_BAD_PAD]);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
